@@ design/srg_pkg.sv @@
// shared types, constants and helpers of the subtractive random generator
package srg_pkg;

   localparam int unsigned TABLE_LEN    = 55;
   localparam int unsigned ADDR_W       = 6;
   localparam int unsigned SEED_STRIDE  = 21;
   localparam int unsigned SECOND_START = 31;
   localparam int unsigned MIX_PASSES   = 4;
   localparam int unsigned MIX_STEPS    = MIX_PASSES * TABLE_LEN;
   localparam int unsigned MIX_CNT_W    = 8;

   localparam logic REQ_RAW    = 1'b0;
   localparam logic REQ_RANGED = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic signed [31:0] range_n;
      logic               reseed;
   } srg_request_type;

   typedef struct packed {
      logic [29:0] raw_value;
      logic [30:0] ranged_value;
   } srg_response_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_FILL,
      ST_MIX_READ,
      ST_MIX_WRITE,
      ST_DRAW_READ,
      ST_DRAW_WRITE,
      ST_MULTIPLY,
      ST_RECIP,
      ST_BACK,
      ST_CORRECT
   } srg_state_type;

   typedef struct packed {
      logic capture;
      logic load_seed;
      logic red_step;
      logic fill_step;
      logic mix_read;
      logic mix_write;
      logic draw_read;
      logic draw_write;
      logic multiply;
      logic recip;
      logic back;
      logic finish_zero;
      logic finish_raw;
      logic finish_ranged;
   } srg_cmd_type;

   typedef struct packed {
      logic seeded;
      logic ranged;
      logic red_done;
      logic fill_done;
      logic mix_done;
   } srg_status_type;

   // circular step over the table
   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(TABLE_LEN - 1)) begin
         r = '0;
      end else begin
         r = a + ADDR_W'(1);
      end
      return r;
   endfunction

endpackage

@@ design/subtractive_random_generator.sv @@
// top level of the subtractive lagged random generator
// Subtractive lagged generator over a 55-word table (ran3 form). An item is taken
// when start is high and busy is low; its result appears on rsp_data for exactly
// one cycle with rsp_valid high and must be taken then, since there is no stall.
// A plain draw reads both lagged words from the table memory, then subtracts,
// writes back and loads the output register. A ranged draw goes on with the
// n * raw product, a reciprocal multiply for the quotient estimate, a multiply
// back for the remainder and a final correction before it strobes. Busy is low
// again in the strobe cycle, so a new item can be taken there, but not while the
// last one is still in progress. A ranged item with n <= 0 strobes zeros in the
// next cycle and busy stays low. The first draw after reset, or one with reseed
// set, first reduces the seed, fills the table and runs four mixing passes, each
// word read and then written. The seed register may be written only while busy
// is low.
module subtractive_random_generator #(
   parameter int unsigned MODULUS = 1000000000
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  srg_pkg::srg_request_type  req_data,
   output logic                      rsp_valid,
   output srg_pkg::srg_response_type rsp_data,
   input  logic                      csr_wr_en,
   input  logic [30:0]               csr_wr_data
);
   import srg_pkg::*;

   srg_cmd_type    cmd;
   srg_status_type status;

   srg_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   srg_datapath #(
      .MODULUS (MODULUS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

@@ design/srg_ram.sv @@
// generic single write, dual read memory with registered read data
module srg_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 55
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ design/srg_controller.sv @@
// sequencer for seeding, mixing, drawing and the ranged scaling
module srg_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  srg_pkg::srg_request_type req_data,
   input  srg_pkg::srg_status_type  status,
   output srg_pkg::srg_cmd_type     cmd,
   output logic                    busy
);
   import srg_pkg::*;

   srg_state_type state_ff;
   srg_state_type state_in;
   logic          zero_req;
   logic          need_seed;

   // ranged request with n <= 0 gives zeros and leaves the generator alone
   assign zero_req  = (req_data.req_type == REQ_RANGED) &&
                      (req_data.range_n[31] || (req_data.range_n == 32'sd0));
   assign need_seed = req_data.reseed || !status.seeded;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (zero_req) begin
                  state_in = ST_IDLE;
               end else if (need_seed) begin
                  state_in = ST_REDUCE;
               end else begin
                  state_in = ST_DRAW_READ;
               end
            end
         end
         ST_REDUCE: begin
            if (status.red_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (status.fill_done) begin
               state_in = ST_MIX_READ;
            end
         end
         ST_MIX_READ: begin
            state_in = ST_MIX_WRITE;
         end
         ST_MIX_WRITE: begin
            if (status.mix_done) begin
               state_in = ST_DRAW_READ;
            end else begin
               state_in = ST_MIX_READ;
            end
         end
         ST_DRAW_READ: begin
            state_in = ST_DRAW_WRITE;
         end
         ST_DRAW_WRITE: begin
            if (status.ranged) begin
               state_in = ST_MULTIPLY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MULTIPLY: begin
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            state_in = ST_BACK;
         end
         ST_BACK: begin
            state_in = ST_CORRECT;
         end
         ST_CORRECT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (zero_req) begin
                  cmd.finish_zero = 1'b1;
               end else if (need_seed) begin
                  cmd.load_seed = 1'b1;
               end
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         ST_MIX_READ: begin
            cmd.mix_read = 1'b1;
         end
         ST_MIX_WRITE: begin
            cmd.mix_write = 1'b1;
         end
         ST_DRAW_READ: begin
            cmd.draw_read = 1'b1;
         end
         ST_DRAW_WRITE: begin
            cmd.draw_write = 1'b1;
            cmd.finish_raw = !status.ranged;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
         end
         ST_BACK: begin
            cmd.back = 1'b1;
         end
         ST_CORRECT: begin
            cmd.finish_ranged = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/srg_datapath.sv @@
// lag table, seed reduction, index registers and reciprocal scaling by the modulus
module srg_datapath #(
   parameter int unsigned MODULUS = 1000000000
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srg_pkg::srg_request_type  req_data,
   input  logic                     csr_wr_en,
   input  logic [30:0]              csr_wr_data,
   input  srg_pkg::srg_cmd_type      cmd,
   output srg_pkg::srg_status_type   status,
   output logic                     rsp_valid,
   output srg_pkg::srg_response_type rsp_data
);
   import srg_pkg::*;

   localparam int unsigned VAL_W     = $clog2(MODULUS);
   localparam int unsigned PROD_W    = 31 + VAL_W;
   localparam int unsigned REM_W     = 34;
   localparam int unsigned RED_STEPS = 32 - VAL_W;
   localparam int unsigned RED_CNT_W = $clog2(RED_STEPS + 1);
   localparam logic [VAL_W:0]    MOD_X   = (VAL_W + 1)'(MODULUS);
   localparam logic [30:0]       RED_TOP = 31'(64'(MODULUS) << (RED_STEPS - 1));
   // floor(2^(VAL_W+31) / MODULUS), below 2^32 for every legal modulus
   localparam logic [31:0]       RECIP   = 32'((64'd1 << (VAL_W + 31)) / 64'(MODULUS));
   localparam logic [REM_W-1:0]  MOD_R   = REM_W'(MODULUS);
   localparam logic [REM_W-1:0]  MOD_R2  = REM_W'(64'(MODULUS) << 1);

   function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
      logic [VAL_W:0] d;
      if (a >= b) begin
         d = {1'b0, a} - {1'b0, b};
      end else begin
         d = {1'b0, a} + (MOD_X - {1'b0, b});
      end
      return d[VAL_W-1:0];
   endfunction

   function automatic logic [29:0] raw_field(input logic [VAL_W-1:0] v);
      logic [31:0] ext;
      ext = 32'(v);
      return ext[29:0];
   endfunction

   // control registers
   logic [30:0]          seed_ff, seed_in;
   logic                 seeded_ff, seeded_in;
   logic [ADDR_W-1:0]    first_addr_ff, first_addr_in;
   logic [ADDR_W-1:0]    second_addr_ff, second_addr_in;
   logic [RED_CNT_W-1:0] red_cnt_ff, red_cnt_in;
   logic [ADDR_W-1:0]    fill_cnt_ff, fill_cnt_in;
   logic [MIX_CNT_W-1:0] mix_cnt_ff, mix_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   srg_request_type      req_ff, req_in;
   logic [30:0]          red_rem_ff, red_rem_in;
   logic [30:0]          red_div_ff, red_div_in;
   logic [VAL_W-1:0]     cur_ff, cur_in;
   logic [VAL_W-1:0]     nxt_ff, nxt_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [ADDR_W-1:0]    mix_a_ff, mix_a_in;
   logic [ADDR_W-1:0]    mix_b_ff, mix_b_in;
   logic [VAL_W-1:0]     raw_ff, raw_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [30:0]          quot_ff, quot_in;
   srg_response_type     rsp_data_ff, rsp_data_in;

   // memory side
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [VAL_W-1:0]     wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr_a;
   logic [ADDR_W-1:0]    rd_addr_b;
   logic [VAL_W-1:0]     rd_data_a;
   logic [VAL_W-1:0]     rd_data_b;
   logic [VAL_W-1:0]     diff;
   logic [ADDR_W:0]      pos_sum;
   logic                 fill_first;

   // scaling side
   logic [31:0]          p_high;
   logic [63:0]          recip_prod;
   logic [30:0]          corr_add;

   srg_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_LEN)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign diff       = sub_mod(rd_data_a, rd_data_b);
   assign fill_first = (fill_cnt_ff == '0);
   assign pos_sum    = {1'b0, pos_ff} + (ADDR_W + 1)'(SEED_STRIDE);

   // quotient estimate from the top 32 product bits is short by at most two
   assign p_high     = prod_ff[PROD_W-1:VAL_W-1];
   assign recip_prod = 64'(p_high) * 64'(RECIP);
   assign corr_add   = (rem_ff >= MOD_R2) ? 31'd3 :
                       ((rem_ff >= MOD_R) ? 31'd2 : 31'd1);

   assign rd_en     = cmd.mix_read | cmd.draw_read;
   assign rd_addr_a = cmd.mix_read ? mix_a_ff : first_addr_ff;
   assign rd_addr_b = cmd.mix_read ? mix_b_ff : second_addr_ff;

   always_comb begin
      wr_en   = cmd.fill_step | cmd.mix_write | cmd.draw_write;
      wr_addr = first_addr_ff;
      wr_data = diff;
      if (cmd.fill_step) begin
         if (fill_first) begin
            wr_addr = ADDR_W'(TABLE_LEN - 1);
            wr_data = red_rem_ff[VAL_W-1:0];
         end else begin
            wr_addr = pos_ff - ADDR_W'(1);
            wr_data = nxt_ff;
         end
      end else if (cmd.mix_write) begin
         wr_addr = mix_a_ff;
      end
   end

   always_comb begin
      seed_in        = seed_ff;
      seeded_in      = seeded_ff;
      first_addr_in  = first_addr_ff;
      second_addr_in = second_addr_ff;
      red_cnt_in     = red_cnt_ff;
      fill_cnt_in    = fill_cnt_ff;
      mix_cnt_in     = mix_cnt_ff;
      req_in         = req_ff;
      red_rem_in     = red_rem_ff;
      red_div_in     = red_div_ff;
      cur_in         = cur_ff;
      nxt_in         = nxt_ff;
      pos_in         = pos_ff;
      mix_a_in       = mix_a_ff;
      mix_b_in       = mix_b_ff;
      raw_in         = raw_ff;
      prod_in        = prod_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      rsp_valid_in   = cmd.finish_zero | cmd.finish_raw | cmd.finish_ranged;
      rsp_data_in    = rsp_data_ff;

      if (csr_wr_en) begin
         seed_in = csr_wr_data;
      end
      if (cmd.capture) begin
         req_in = req_data;
      end
      if (cmd.load_seed) begin
         red_rem_in  = (seed_ff == '0) ? 31'd1 : (seed_ff - 31'd1);
         red_div_in  = RED_TOP;
         red_cnt_in  = '0;
         fill_cnt_in = '0;
         mix_a_in    = '0;
         mix_b_in    = ADDR_W'(SECOND_START);
         mix_cnt_in  = '0;
      end
      // start mod MODULUS, one shifted compare and subtract per cycle
      if (cmd.red_step) begin
         if (red_rem_ff >= red_div_ff) begin
            red_rem_in = red_rem_ff - red_div_ff;
         end
         red_div_in = red_div_ff >> 1;
         red_cnt_in = red_cnt_ff + RED_CNT_W'(1);
      end
      // initial fill follows the stride-21 permutation of the table
      if (cmd.fill_step) begin
         fill_cnt_in = fill_cnt_ff + ADDR_W'(1);
         if (fill_first) begin
            cur_in = red_rem_ff[VAL_W-1:0];
            nxt_in = VAL_W'(1);
            pos_in = ADDR_W'(SEED_STRIDE);
         end else begin
            nxt_in = sub_mod(cur_ff, nxt_ff);
            cur_in = nxt_ff;
            if (pos_sum >= (ADDR_W + 1)'(TABLE_LEN)) begin
               pos_in = ADDR_W'(pos_sum - (ADDR_W + 1)'(TABLE_LEN));
            end else begin
               pos_in = pos_sum[ADDR_W-1:0];
            end
         end
      end
      if (cmd.mix_write) begin
         mix_a_in   = next_addr(mix_a_ff);
         mix_b_in   = next_addr(mix_b_ff);
         mix_cnt_in = mix_cnt_ff + MIX_CNT_W'(1);
         if (status.mix_done) begin
            seeded_in      = 1'b1;
            first_addr_in  = '0;
            second_addr_in = ADDR_W'(SECOND_START);
         end
      end
      if (cmd.draw_write) begin
         raw_in         = diff;
         first_addr_in  = next_addr(first_addr_ff);
         second_addr_in = next_addr(second_addr_ff);
      end
      if (cmd.multiply) begin
         prod_in = PROD_W'(req_ff.range_n[30:0]) * PROD_W'(raw_ff);
      end
      if (cmd.recip) begin
         quot_in = recip_prod[62:32];
      end
      // remainder is below three times MODULUS, so its low bits suffice
      if (cmd.back) begin
         rem_in = prod_ff[REM_W-1:0] - (REM_W'(quot_ff) * MOD_R);
      end

      if (cmd.finish_zero) begin
         rsp_data_in = '0;
      end else if (cmd.finish_raw) begin
         rsp_data_in.raw_value    = raw_field(diff);
         rsp_data_in.ranged_value = '0;
      end else if (cmd.finish_ranged) begin
         rsp_data_in.raw_value    = raw_field(raw_ff);
         rsp_data_in.ranged_value = quot_ff + corr_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff        <= '0;
         seeded_ff      <= 1'b0;
         first_addr_ff  <= '0;
         second_addr_ff <= ADDR_W'(SECOND_START);
         red_cnt_ff     <= '0;
         fill_cnt_ff    <= '0;
         mix_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         seed_ff        <= seed_in;
         seeded_ff      <= seeded_in;
         first_addr_ff  <= first_addr_in;
         second_addr_ff <= second_addr_in;
         red_cnt_ff     <= red_cnt_in;
         fill_cnt_ff    <= fill_cnt_in;
         mix_cnt_ff     <= mix_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      red_rem_ff  <= red_rem_in;
      red_div_ff  <= red_div_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      pos_ff      <= pos_in;
      mix_a_ff    <= mix_a_in;
      mix_b_ff    <= mix_b_in;
      raw_ff      <= raw_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.seeded    = seeded_ff;
   assign status.ranged    = (req_ff.req_type == REQ_RANGED);
   assign status.red_done  = (red_cnt_ff == RED_CNT_W'(RED_STEPS - 1));
   assign status.fill_done = (fill_cnt_ff == ADDR_W'(TABLE_LEN - 1));
   assign status.mix_done  = (mix_cnt_ff == MIX_CNT_W'(MIX_STEPS - 1));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_draw_after_seed: assert property (@(posedge clock) disable iff (reset)
      cmd.draw_write |-> seeded_ff)
      else $error("draw from a table that was never seeded");

   a_mix_lag_apart: assert property (@(posedge clock) disable iff (reset)
      cmd.mix_write |-> (mix_a_ff != mix_b_ff) && (mix_a_ff < ADDR_W'(TABLE_LEN)))
      else $error("mixing lags out of step");

   a_ranged_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.ranged_value != '0)) |->
         (req_ff.req_type == REQ_RANGED) &&
         (rsp_data_ff.ranged_value <= req_ff.range_n[30:0]))
      else $error("ranged item outside 1..n");

   a_finish_strobe: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_zero || cmd.finish_raw || cmd.finish_ranged) |=> rsp_valid_ff)
      else $error("finished item not strobed");
`endif

endmodule
